// ===== src/rrs_pkg.sv =====
// ----------------------------------------------------------------------------
// rrs_pkg
// Field widths, register codes and the job table access types shared by the
// round-robin schedule simulator.
// ----------------------------------------------------------------------------
`default_nettype none

package rrs_pkg;

  localparam int ARR_W     = 16;
  localparam int BURST_W   = 12;
  localparam int QUANT_W   = 12;
  localparam int TIME_W    = 18;
  // one bit above the result width so late ticks never alias an arrival
  localparam int TICK_W    = 19;
  localparam int JOB_IDX_W = 4;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  // register index, taken from paddr[2]
  localparam logic REG_QUANTUM = 1'b0;

  localparam logic [QUANT_W-1:0] QUANTUM_RESET = 12'd4;

  typedef struct packed {
    logic               load_en;
    logic               rem_en;
    logic               fin_en;
    logic [ARR_W-1:0]   arrival;
    logic [BURST_W-1:0] burst;
    logic [BURST_W-1:0] remaining;
    logic [TIME_W-1:0]  finish;
  } job_wr_t;

  typedef struct packed {
    logic [ARR_W-1:0]   arrival;
    logic [BURST_W-1:0] burst;
    logic [BURST_W-1:0] remaining;
    logic [TIME_W-1:0]  finish;
  } job_rd_t;

endpackage

`default_nettype wire

// ===== src/rrs_job_mem.sv =====
// ----------------------------------------------------------------------------
// rrs_job_mem
// Job table: arrival, burst, remaining service and finish tick per job, one
// write port with field enables and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rrs_job_mem
  import rrs_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4
) (
  input  wire logic             clk_i,
  input  wire logic [IDX_W-1:0] rd_addr_i,
  output job_rd_t               rd_data_o,
  input  wire logic [IDX_W-1:0] wr_addr_i,
  input  wire job_wr_t          wr_i
);

  logic [ARR_W-1:0]   arr_mem   [DEPTH];
  logic [BURST_W-1:0] burst_mem [DEPTH];
  logic [BURST_W-1:0] rem_mem   [DEPTH];
  logic [TIME_W-1:0]  fin_mem   [DEPTH];

  job_rd_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.load_en) begin
      arr_mem[wr_addr_i]   <= wr_i.arrival;
      burst_mem[wr_addr_i] <= wr_i.burst;
    end
    if (wr_i.load_en || wr_i.rem_en) begin
      rem_mem[wr_addr_i] <= wr_i.remaining;
    end
    if (wr_i.fin_en) begin
      fin_mem[wr_addr_i] <= wr_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q.arrival   <= arr_mem[rd_addr_i];
    rd_data_q.burst     <= burst_mem[rd_addr_i];
    rd_data_q.remaining <= rem_mem[rd_addr_i];
    rd_data_q.finish    <= fin_mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== src/rrs_ready_queue.sv =====
// ----------------------------------------------------------------------------
// rrs_ready_queue
// FIFO of ready job indexes held in a small memory; the popped index is
// registered and shows on pop_data_o in the cycle after the pop.
// ----------------------------------------------------------------------------
`default_nettype none

module rrs_ready_queue #(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4,
  parameter int CNT_W = 5
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             clear_i,
  input  wire logic             push_i,
  input  wire logic [IDX_W-1:0] push_data_i,
  input  wire logic             pop_i,
  output logic      [IDX_W-1:0] pop_data_o,
  output logic      [CNT_W-1:0] count_o
);

  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

  logic [IDX_W-1:0] q_mem [DEPTH];
  logic [IDX_W-1:0] head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] pop_data_q;
  logic             do_push, do_pop;

  assign do_push = push_i && (count_q != FULL_CNT);
  assign do_pop  = pop_i && (count_q != '0);

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (clear_i) begin
      head_d  = '0;
      tail_d  = '0;
      count_d = '0;
    end else begin
      if (do_push) begin
        tail_d = (tail_q == LAST_SLOT) ? '0 : tail_q + 1'b1;
      end
      if (do_pop) begin
        head_d = (head_q == LAST_SLOT) ? '0 : head_q + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count_d = count_q + 1'b1;
        2'b01:   count_d = count_q - 1'b1;
        default: count_d = count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push && !clear_i) begin
      q_mem[tail_q] <= push_data_i;
    end
    if (do_pop) begin
      pop_data_q <= q_mem[head_q];
    end
  end

  assign pop_data_o = pop_data_q;
  assign count_o    = count_q;

endmodule

`default_nettype wire

// ===== src/rrs_result_unit.sv =====
// ----------------------------------------------------------------------------
// rrs_result_unit
// Turns job table read data into one result beat per job: completion,
// turnaround and waiting time, held in a result register behind stage 1.
// ----------------------------------------------------------------------------
`default_nettype none

module rrs_result_unit
  import rrs_pkg::*;
#(
  parameter int IDX_W = 4
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 issue_i,
  input  wire logic [IDX_W-1:0]     issue_idx_i,
  input  wire logic                 issue_last_i,
  input  wire job_rd_t              rd_data_i,
  output logic                      result_valid_o,
  output logic      [JOB_IDX_W-1:0] job_index_o,
  output logic      [TIME_W-1:0]    completion_time_o,
  output logic      [TIME_W-1:0]    turnaround_time_o,
  output logic      [TIME_W-1:0]    waiting_time_o,
  output logic                      last_result_o
);

  // stage 1 lines up with the registered table read
  logic             s1_valid_q;
  logic [IDX_W-1:0] s1_idx_q;
  logic             s1_last_q;

  logic                 res_valid_q;
  logic [JOB_IDX_W-1:0] res_idx_q;
  logic [TIME_W-1:0]    res_done_q, res_turn_q, res_wait_q;
  logic                 res_last_q;
  logic [TIME_W-1:0]    turn_d, wait_d;

  assign turn_d = rd_data_i.finish - TIME_W'(rd_data_i.arrival);
  assign wait_d = turn_d - TIME_W'(rd_data_i.burst);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= issue_i;
      res_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q  <= issue_idx_i;
    s1_last_q <= issue_last_i;
    if (s1_valid_q) begin
      res_idx_q  <= JOB_IDX_W'(s1_idx_q);
      res_done_q <= rd_data_i.finish;
      res_turn_q <= turn_d;
      res_wait_q <= wait_d;
      res_last_q <= s1_last_q;
    end
  end

  assign result_valid_o    = res_valid_q;
  assign job_index_o       = res_idx_q;
  assign completion_time_o = res_done_q;
  assign turnaround_time_o = res_turn_q;
  assign waiting_time_o    = res_wait_q;
  assign last_result_o     = res_last_q;

endmodule

`default_nettype wire

// ===== src/round_robin_schedule_simulator.sv =====
// ----------------------------------------------------------------------------
// round_robin_schedule_simulator
// Loads a set of jobs, simulates round-robin scheduling over them and reports
// completion, turnaround and waiting time for every job.
// ----------------------------------------------------------------------------
// Usage:
//   Jobs are loaded one beat per cycle: start high while busy is low takes
//   arrival_time_i, burst_length_i and last_job_i. A beat with last_job_i set,
//   or the beat that fills the last of MAX_JOBS slots, closes the set and
//   raises busy until the last result read has been issued.
//   The scheduler jumps time straight to the next event (an arrival or the end
//   of a slice or burst). Each arrival tick, and tick 0, costs a scan of the
//   job table; each dispatch steps through decide, pop, fetch, run and slice
//   end, with one more run step per arrival inside the slice.
//   Event count, not elapsed ticks, sets the run time.
//   Results follow as one beat per cycle in job order, marked by
//   result_valid_o, behind the registered table read and the result register;
//   the receiver cannot stall them. busy falls as the last read issues, so the
//   final two beats appear while the next set may already be loading.
//   time_quantum sits at byte address 0 of the APB port (reset 4, zero acts
//   as 1) and must be written only while the block is idle (not enforced).
//   Reset empties the queue and returns to loading; the job table is not
//   cleared, only written entries are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module round_robin_schedule_simulator
  import rrs_pkg::*;
#(
  parameter int MAX_JOBS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // job load channel
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [ARR_W-1:0]     arrival_time_i,
  input  wire logic [BURST_W-1:0]   burst_length_i,
  input  wire logic                 last_job_i,
  // result channel
  output logic                      result_valid_o,
  output logic      [JOB_IDX_W-1:0] job_index_o,
  output logic      [TIME_W-1:0]    completion_time_o,
  output logic      [TIME_W-1:0]    turnaround_time_o,
  output logic      [TIME_W-1:0]    waiting_time_o,
  output logic                      last_result_o,
  // configuration
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [APB_AW-1:0]    paddr,
  input  wire logic [APB_DW-1:0]    pwdata,
  output logic      [APB_DW-1:0]    prdata,
  output logic                      pready
);

  localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNT_W = $clog2(MAX_JOBS + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_JOBS);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_DECIDE,
    ST_POP,
    ST_FETCH,
    ST_RUN,
    ST_END,
    ST_OUT
  } state_e;

  state_e             state_q;
  logic [QUANT_W-1:0] quantum_q;
  logic [CNT_W-1:0]   loaded_q, count_q, finished_q;
  logic [TICK_W-1:0]  tick_q;
  logic [CNT_W-1:0]   scan_addr_q;
  logic               scan_vld_q;
  logic [IDX_W-1:0]   scan_idx_q;
  logic [ARR_W-1:0]   next_arr_q;
  logic               next_vld_q;
  logic [IDX_W-1:0]   cur_job_q;
  logic [BURST_W-1:0] rem_q, slice_q;
  logic               running_q;
  logic [CNT_W-1:0]   out_addr_q;

  // ---------------- configuration port ----------------
  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_QUANTUM) ? APB_DW'(quantum_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q <= QUANTUM_RESET;
    end else if (cfg_wr && paddr[2] == REG_QUANTUM) begin
      quantum_q <= pwdata[QUANT_W-1:0];
    end
  end

  // ---------------- datapath helpers ----------------
  logic               accept, set_done;
  logic [CNT_W-1:0]   loaded_inc;
  logic [QUANT_W-1:0] slice_len;
  job_rd_t            rd_data;
  job_wr_t            wr_req;
  logic [IDX_W-1:0]   rd_addr, wr_addr;
  logic [IDX_W-1:0]   pop_data;
  logic [CNT_W-1:0]   q_count;
  logic               q_push, q_pop, q_clear;
  logic [IDX_W-1:0]   q_push_data;
  logic               scan_issue, scan_last, arr_match, arr_later;
  logic [TICK_W-1:0]  arr_tick, next_diff;
  logic [BURST_W-1:0] seg_a, seg;
  logic               hit_arr;
  logic               out_last;

  assign busy       = (state_q != ST_LOAD);
  assign accept     = start && !busy;
  assign loaded_inc = loaded_q + 1'b1;
  assign set_done   = last_job_i || (loaded_inc == MAX_CNT);
  assign slice_len  = (quantum_q == '0) ? QUANT_W'(1) : quantum_q;

  assign scan_issue = (state_q == ST_SCAN) && (scan_addr_q < count_q);
  assign scan_last  = scan_vld_q && ((CNT_W'(scan_idx_q) + 1'b1) == count_q);
  assign arr_tick   = TICK_W'(rd_data.arrival);
  assign arr_match  = (arr_tick == tick_q);
  assign arr_later  = (arr_tick > tick_q) &&
                      (!next_vld_q || rd_data.arrival < next_arr_q);

  // a slice segment stops at the slice end, the burst end or the next arrival
  assign next_diff = TICK_W'(next_arr_q) - tick_q;
  assign seg_a     = (rem_q < slice_q) ? rem_q : slice_q;
  assign hit_arr   = next_vld_q && (next_diff <= TICK_W'(seg_a));
  assign seg       = hit_arr ? next_diff[BURST_W-1:0] : seg_a;

  assign out_last  = ((out_addr_q + 1'b1) == count_q);

  always_comb begin
    unique case (state_q)
      ST_POP:  rd_addr = pop_data;
      ST_OUT:  rd_addr = out_addr_q[IDX_W-1:0];
      default: rd_addr = scan_addr_q[IDX_W-1:0];
    endcase
  end

  always_comb begin
    wr_req           = '0;
    wr_req.arrival   = arrival_time_i;
    wr_req.burst     = burst_length_i;
    wr_req.remaining = burst_length_i;
    wr_req.finish    = tick_q[TIME_W-1:0];
    wr_addr          = loaded_q[IDX_W-1:0];
    if (state_q == ST_END) begin
      wr_addr          = cur_job_q;
      wr_req.remaining = rem_q;
      wr_req.fin_en    = (rem_q == '0);
      wr_req.rem_en    = (rem_q != '0);
    end else begin
      wr_req.load_en   = accept;
    end
  end

  // arrivals of this tick go in before a preempted job
  always_comb begin
    q_push      = 1'b0;
    q_push_data = scan_idx_q;
    if (state_q == ST_SCAN) begin
      q_push = scan_vld_q && arr_match;
    end else if (state_q == ST_END) begin
      q_push      = (rem_q != '0);
      q_push_data = cur_job_q;
    end
  end

  assign q_pop   = (state_q == ST_DECIDE) && (finished_q != count_q) && (q_count != '0);
  assign q_clear = accept && set_done;

  // ---------------- control ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      loaded_q    <= '0;
      count_q     <= '0;
      finished_q  <= '0;
      tick_q      <= '0;
      scan_addr_q <= '0;
      scan_vld_q  <= 1'b0;
      scan_idx_q  <= '0;
      next_arr_q  <= '0;
      next_vld_q  <= 1'b0;
      cur_job_q   <= '0;
      rem_q       <= '0;
      slice_q     <= '0;
      running_q   <= 1'b0;
      out_addr_q  <= '0;
    end else begin
      unique case (state_q)
        ST_LOAD: begin
          if (accept) begin
            loaded_q <= loaded_inc;
            if (set_done) begin
              count_q     <= loaded_inc;
              finished_q  <= '0;
              tick_q      <= '0;
              running_q   <= 1'b0;
              scan_addr_q <= '0;
              next_vld_q  <= 1'b0;
              state_q     <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          scan_vld_q  <= scan_issue;
          scan_idx_q  <= scan_addr_q[IDX_W-1:0];
          scan_addr_q <= scan_addr_q + CNT_W'(scan_issue);
          if (scan_vld_q && arr_later) begin
            next_arr_q <= rd_data.arrival;
            next_vld_q <= 1'b1;
          end
          if (scan_last) begin
            if (!running_q) begin
              state_q <= ST_DECIDE;
            end else if (rem_q != '0 && slice_q != '0) begin
              state_q <= ST_RUN;
            end else begin
              state_q <= ST_END;
            end
          end
        end
        ST_DECIDE: begin
          if (finished_q == count_q) begin
            out_addr_q <= '0;
            state_q    <= ST_OUT;
          end else if (q_count == '0) begin
            // idle: jump to the next arrival
            tick_q      <= TICK_W'(next_arr_q);
            scan_addr_q <= '0;
            next_vld_q  <= 1'b0;
            state_q     <= ST_SCAN;
          end else begin
            state_q <= ST_POP;
          end
        end
        ST_POP: begin
          cur_job_q <= pop_data;
          state_q   <= ST_FETCH;
        end
        ST_FETCH: begin
          rem_q     <= rd_data.remaining;
          slice_q   <= slice_len;
          running_q <= 1'b1;
          state_q   <= ST_RUN;
        end
        ST_RUN: begin
          tick_q  <= tick_q + TICK_W'(seg);
          rem_q   <= rem_q - seg;
          slice_q <= slice_q - seg;
          if (hit_arr) begin
            scan_addr_q <= '0;
            next_vld_q  <= 1'b0;
            state_q     <= ST_SCAN;
          end else begin
            state_q <= ST_END;
          end
        end
        ST_END: begin
          if (rem_q == '0) begin
            finished_q <= finished_q + 1'b1;
          end
          running_q <= 1'b0;
          state_q   <= ST_DECIDE;
        end
        ST_OUT: begin
          out_addr_q <= out_addr_q + 1'b1;
          if (out_last) begin
            loaded_q <= '0;
            state_q  <= ST_LOAD;
          end
        end
        default: state_q <= ST_LOAD;
      endcase
    end
  end

  // ---------------- submodules ----------------
  rrs_job_mem #(
    .DEPTH (MAX_JOBS),
    .IDX_W (IDX_W)
  ) u_job_mem (
    .clk_i     (clk_i),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_addr_i (wr_addr),
    .wr_i      (wr_req)
  );

  rrs_ready_queue #(
    .DEPTH (MAX_JOBS),
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_ready_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (q_clear),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .pop_i       (q_pop),
    .pop_data_o  (pop_data),
    .count_o     (q_count)
  );

  rrs_result_unit #(
    .IDX_W (IDX_W)
  ) u_result_unit (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .issue_i           (state_q == ST_OUT),
    .issue_idx_i       (out_addr_q[IDX_W-1:0]),
    .issue_last_i      (out_last),
    .rd_data_i         (rd_data),
    .result_valid_o    (result_valid_o),
    .job_index_o       (job_index_o),
    .completion_time_o (completion_time_o),
    .turnaround_time_o (turnaround_time_o),
    .waiting_time_o    (waiting_time_o),
    .last_result_o     (last_result_o)
  );

  // ---------------- assertions ----------------
  a_next_arrival_ahead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && next_vld_q) |-> (TICK_W'(next_arr_q) > tick_q))
    else $error("pending arrival is not ahead of the current tick");

  a_finished_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> (finished_q <= count_q && q_count <= count_q))
    else $error("finished or queued jobs exceed the loaded set");

  a_set_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last_job_i) |=> (state_q == ST_SCAN && tick_q == '0))
    else $error("closing beat did not start the schedule at tick zero");

  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q == ST_OUT, 2))
    else $error("result beat without a matching table read");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the round-robin schedule simulator: loads job sets
// over the start/busy channel and reprograms the quantum over APB between
// phases. The bench runs its own round-robin schedule for every closed set and
// checks each result beat, field by field, in job order.
// ----------------------------------------------------------------------------
module tb_top;
  import rrs_pkg::*;

  localparam int JOBS_MAX = 16;
  localparam logic [APB_AW-1:0] QUANTUM_ADDR = {REG_QUANTUM, 2'b00};
  localparam logic [APB_AW-1:0] SPARE_ADDR   = {~REG_QUANTUM, 2'b00};
  localparam int PHASE_ITEMS = 30;
  localparam int DRAIN_LIMIT = 300000;

  typedef struct packed {
    logic [JOB_IDX_W-1:0] job_idx;
    logic [TIME_W-1:0]    completion;
    logic [TIME_W-1:0]    turnaround;
    logic [TIME_W-1:0]    waiting;
    logic                 last_flag;
  } job_report_t;

  class schedule_scoreboard;
    logic [QUANT_W-1:0] quantum;
    logic [ARR_W-1:0]   arrival [JOBS_MAX];
    logic [BURST_W-1:0] burst [JOBS_MAX];
    int unsigned        loaded;
    int unsigned        ready_q[$];
    job_report_t        pending_reports[$];
    int unsigned        errors;
    int unsigned        checked;
    int unsigned        sets;

    function new();
      quantum = QUANTUM_RESET;
      loaded  = 0;
      errors  = 0;
      checked = 0;
      sets    = 0;
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    // earliest arrival strictly after the given tick, all ones if none
    function int unsigned next_arrival(int unsigned after);
      int unsigned best;
      int unsigned j;
      best = 32'hFFFF_FFFF;
      for (j = 0; j < loaded; j++) begin
        if (arrival[j] > after && arrival[j] < best) best = arrival[j];
      end
      return best;
    endfunction

    function void admit(int unsigned at);
      int unsigned j;
      for (j = 0; j < loaded; j++) begin
        if (arrival[j] == at) ready_q.push_back(j);
      end
    endfunction

    // event-driven round robin: idle stretches jump straight to the next arrival,
    // slices to their end, and arrivals inside a slice queue ahead of the requeue
    function void schedule_round_robin();
      int unsigned slice, tick, end_tick, nxt, run, done_cnt, job, turn, waitv, j;
      int unsigned left[JOBS_MAX];
      int unsigned fin[JOBS_MAX];
      job_report_t r;
      slice = (quantum == '0) ? 1 : quantum;
      ready_q.delete();
      for (j = 0; j < loaded; j++) left[j] = burst[j];
      tick = 0;
      done_cnt = 0;
      admit(0);
      while (done_cnt < loaded) begin
        if (ready_q.size() == 0) begin
          tick = next_arrival(tick);
          admit(tick);
        end else begin
          job = ready_q.pop_front();
          run = (left[job] < slice) ? left[job] : slice;
          end_tick = tick + run;
          nxt = next_arrival(tick);
          while (nxt <= end_tick) begin
            admit(nxt);
            tick = nxt;
            nxt = next_arrival(tick);
          end
          tick = end_tick;
          left[job] -= run;
          if (left[job] == 0) begin
            fin[job] = tick;
            done_cnt++;
          end else begin
            ready_q.push_back(job);
          end
        end
      end
      for (j = 0; j < loaded; j++) begin
        turn = fin[j] - arrival[j];
        waitv = turn - burst[j];
        r.job_idx    = j[JOB_IDX_W-1:0];
        r.completion = fin[j][TIME_W-1:0];
        r.turnaround = turn[TIME_W-1:0];
        r.waiting    = waitv[TIME_W-1:0];
        r.last_flag  = (j == loaded - 1);
        pending_reports.push_back(r);
      end
    endfunction

    function void note_job(logic [ARR_W-1:0] arr, logic [BURST_W-1:0] brst,
                           logic close_set);
      arrival[loaded] = arr;
      burst[loaded] = brst;
      loaded++;
      // a full table closes the set even without last_job
      if (close_set || loaded == JOBS_MAX) begin
        schedule_round_robin();
        sets++;
        loaded = 0;
      end
    endfunction

    task compare_field(string name, logic [TIME_W-1:0] got, logic [TIME_W-1:0] want,
                       logic [JOB_IDX_W-1:0] job);
      if (got !== want)
        report($sformatf("job %0d %s: got %0d, expected %0d", job, name, got, want));
    endtask

    task check_result(logic [JOB_IDX_W-1:0] idx, logic [TIME_W-1:0] done,
                      logic [TIME_W-1:0] turn, logic [TIME_W-1:0] waitv,
                      logic last_flag);
      job_report_t want;
      checked++;
      if (pending_reports.size() == 0) begin
        report($sformatf("result beat for job %0d with nothing pending", idx));
        return;
      end
      want = pending_reports.pop_front();
      compare_field("job_index", TIME_W'(idx), TIME_W'(want.job_idx), want.job_idx);
      compare_field("completion_time", done, want.completion, want.job_idx);
      compare_field("turnaround_time", turn, want.turnaround, want.job_idx);
      compare_field("waiting_time", waitv, want.waiting, want.job_idx);
      compare_field("last_result", TIME_W'(last_flag), TIME_W'(want.last_flag),
                    want.job_idx);
    endtask
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic [ARR_W-1:0]     arrival_time_i;
  logic [BURST_W-1:0]   burst_length_i;
  logic                 last_job_i;
  logic                 result_valid_o;
  logic [JOB_IDX_W-1:0] job_index_o;
  logic [TIME_W-1:0]    completion_time_o;
  logic [TIME_W-1:0]    turnaround_time_o;
  logic [TIME_W-1:0]    waiting_time_o;
  logic                 last_result_o;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [APB_AW-1:0]    paddr;
  logic [APB_DW-1:0]    pwdata;
  logic [APB_DW-1:0]    prdata;
  logic                 pready;

  schedule_scoreboard sb = new();
  int unsigned gap_cap;
  int unsigned jobs_sent;
  int unsigned quanta_written;

  round_robin_schedule_simulator #(
    .MAX_JOBS(JOBS_MAX)
  ) i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .arrival_time_i   (arrival_time_i),
    .burst_length_i   (burst_length_i),
    .last_job_i       (last_job_i),
    .result_valid_o   (result_valid_o),
    .job_index_o      (job_index_o),
    .completion_time_o(completion_time_o),
    .turnaround_time_o(turnaround_time_o),
    .waiting_time_o   (waiting_time_o),
    .last_result_o    (last_result_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      sb.check_result(job_index_o, completion_time_o, turnaround_time_o,
                      waiting_time_o, last_result_o);
    end
  end

  task automatic send_job(input logic [ARR_W-1:0] arr, input logic [BURST_W-1:0] brst,
                          input logic close_set);
    int unsigned gap;
    gap = $urandom_range(0, gap_cap);
    @(negedge clk_i);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    arrival_time_i <= arr;
    burst_length_i <= brst;
    last_job_i <= close_set;
    do @(posedge clk_i); while (busy);
    sb.note_job(arr, brst, close_set);
    jobs_sent++;
  endtask

  task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == QUANTUM_ADDR) sb.quantum = data[QUANT_W-1:0];
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic check_quantum();
    logic [APB_DW-1:0] got;
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= QUANTUM_ADDR;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    if (got !== APB_DW'(sb.quantum))
      sb.report($sformatf("time_quantum read %0d, expected %0d", got, sb.quantum));
  endtask

  // drop start after the last beat and let every pending result come out
  task automatic drain();
    int unsigned waited;
    @(negedge clk_i);
    start <= 1'b0;
    waited = 0;
    while (sb.pending_reports.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (16) @(posedge clk_i);
  endtask

  task automatic random_set(input int unsigned burst_cap, output int unsigned sent);
    int unsigned len, j, pick, span;
    logic [ARR_W-1:0]   arr;
    logic [BURST_W-1:0] brst;
    logic               close_set;
    pick = $urandom_range(0, 9);
    if (pick < 6) len = $urandom_range(1, 4);
    else if (pick < 8) len = $urandom_range(5, 10);
    else len = JOBS_MAX;
    gap_cap = ($urandom_range(0, 2) == 0) ? 0 : 8;
    span = 3 * len;
    for (j = 0; j < len; j++) begin
      if ($urandom_range(0, 4) == 0) arr = ARR_W'($urandom_range(0, 65535));
      else arr = ARR_W'($urandom_range(0, span));
      pick = $urandom_range(0, 19);
      if (pick == 0) brst = '0;
      else if (pick == 1) brst = BURST_W'(burst_cap);
      else brst = BURST_W'($urandom_range(0, burst_cap));
      // a full set may close on the table filling up instead of last_job
      close_set = (j == len - 1) && (len < JOBS_MAX || $urandom_range(0, 1) == 1);
      send_job(arr, brst, close_set);
    end
    sent = len;
  endtask

  initial begin
    int unsigned plan[] = '{1, 4095, 0, 2, 3, 5, 8, 16, 64, 1000, 4095, 1};
    int unsigned p, j, slice, cap, phase_items, sent;
    start = 1'b0;
    arrival_time_i = '0;
    burst_length_i = '0;
    last_job_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rst_ni = 1'b0;
    jobs_sent = 0;
    quanta_written = 0;
    gap_cap = 3;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    check_quantum();

    // directed sets at the reset quantum
    send_job(16'd0, 12'd0, 1'b1);         // zero burst finishes at once
    send_job(16'd0, 12'd5, 1'b0);         // tie at tick 0, then an arrival
    send_job(16'd0, 12'd3, 1'b0);         // lands ahead of a requeue
    send_job(16'd2, 12'd4, 1'b1);
    send_job(16'd100, 12'd7, 1'b0);       // idle lead-in and long idle gap
    send_job(16'hFFFF, 12'hFFF, 1'b1);
    for (j = 0; j < JOBS_MAX; j++)        // full table without last_job
      send_job(16'(j % 3), 12'((j * 5) % 9), 1'b0);
    drain();

    for (p = 0; p < plan.size(); p++) begin
      if (p == 0) apb_write(SPARE_ADDR, $urandom());
      apb_write(QUANTUM_ADDR, ($urandom() & 32'hFFFF_F000) | plan[p]);
      quanta_written++;
      check_quantum();
      slice = (plan[p] == 0) ? 1 : plan[p];
      cap = (slice * 6 > 4095) ? 4095 : slice * 6;
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        random_set(cap, sent);
        phase_items += sent;
      end
      drain();
    end

    if (sb.pending_reports.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending_reports.size()));
    $display("loaded %0d jobs in %0d sets, checked %0d result beats",
             jobs_sent, sb.sets, sb.checked);
    $display("quantum: reset value plus %0d writes, zero, one and 4095 among them",
             quanta_written);
    if (sb.errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout: %0d results still pending", sb.pending_reports.size());
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
